// ===== rtl/core/irpte_pkg.sv =====
// Shared constants, types and codes for the infrared pulse train encoder.
`default_nettype none

package irpte_pkg;

  localparam int MAX_DATA_BITS = 30;
  localparam int TICK_BITS     = 16;
  localparam int DATA_W        = 30;
  localparam int TICKS_W       = 16;
  localparam int SEG_W         = 17;
  localparam int LEVEL_POS     = 16;
  localparam int PAIR_W        = 2 * SEG_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = PAIR_W;
  localparam int BC_W          = 5;
  localparam int FE_W          = 2;
  localparam int CNT_W         = $clog2(MAX_DATA_BITS + 1);
  localparam int POS_W         = (MAX_DATA_BITS > 1) ? $clog2(MAX_DATA_BITS) : 1;

  localparam logic [BC_W-1:0] BIT_COUNT_RST = BC_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEG_LOGIC      = 3'd0,
    REG_MSB_FIRST      = 3'd1,
    REG_BIT_COUNT      = 3'd2,
    REG_FRAMING_ENABLE = 3'd3,
    REG_START_PAIR     = 3'd4,
    REG_ZERO_PAIR      = 3'd5,
    REG_ONE_PAIR       = 3'd6,
    REG_STOP_PAIR      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_DATA  = 2'd2,
    ST_STOP  = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic              neg_logic;
    logic              msb_first;
    logic [BC_W-1:0]   bit_count;
    logic [FE_W-1:0]   framing_enable;
    logic [PAIR_W-1:0] start_pair;
    logic [PAIR_W-1:0] zero_pair;
    logic [PAIR_W-1:0] one_pair;
    logic [PAIR_W-1:0] stop_pair;
  } cfg_t;

  typedef struct packed {
    logic               level;
    logic [TICKS_W-1:0] ticks;
    logic               last;
  } seg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ir_pulse_train_encoder.sv =====
// Top level of the infrared pulse train encoder.
//
// Input channel (in_valid_i/in_ready_o) takes one data value per beat; the
// output channel (out_valid_o/out_ready_i) gives one segment per beat: level,
// duration in ticks and a flag on the final segment of the train.
// A value yields two segments per enabled framing pair and two per data bit,
// up to 64 in all; an empty frame yields none.
// The sequencer emits one segment per cycle into the output register while the
// receiver does not stall; an accepted value is held in the sequencer registers
// and in_ready_o stays low while a train is in progress. The output register
// lets the last segment wait while the next value is accepted.
// A stalled receiver holds the output register and the sequencer with it.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while idle, which the block itself does not enforce.
// Reset empties the output register, returns the sequencer to idle and sets
// every register to zero except bit_count, which comes up as 8.
`default_nettype none

module ir_pulse_train_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpte_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [irpte_pkg::DATA_W-1:0]     data_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pulse_level_o,
  output logic [irpte_pkg::TICKS_W-1:0]    pulse_ticks_o,
  output logic                             last_pulse_o
);
  import irpte_pkg::*;

  cfg_t cfg;
  seg_t seg;
  logic seg_valid;
  logic seg_ready;

  irpte_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpte_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_value_i (data_value_i),
    .seg_valid_o  (seg_valid),
    .seg_ready_i  (seg_ready),
    .seg_o        (seg)
  );

  irpte_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seg_valid_i   (seg_valid),
    .seg_ready_o   (seg_ready),
    .seg_i         (seg),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pulse_level_o (pulse_level_o),
    .pulse_ticks_o (pulse_ticks_o),
    .last_pulse_o  (last_pulse_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/irpte_cfg.sv =====
// Configuration register file of the infrared pulse train encoder.
`default_nettype none

module irpte_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpte_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output irpte_pkg::cfg_t                  cfg_o
);
  import irpte_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q           <= '0;
      cfg_q.bit_count <= BIT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NEG_LOGIC:      cfg_q.neg_logic      <= cfg_wdata_i[0];
        REG_MSB_FIRST:      cfg_q.msb_first      <= cfg_wdata_i[0];
        REG_BIT_COUNT:      cfg_q.bit_count      <= cfg_wdata_i[BC_W-1:0];
        REG_FRAMING_ENABLE: cfg_q.framing_enable <= cfg_wdata_i[FE_W-1:0];
        REG_START_PAIR:     cfg_q.start_pair     <= cfg_wdata_i[PAIR_W-1:0];
        REG_ZERO_PAIR:      cfg_q.zero_pair      <= cfg_wdata_i[PAIR_W-1:0];
        REG_ONE_PAIR:       cfg_q.one_pair       <= cfg_wdata_i[PAIR_W-1:0];
        REG_STOP_PAIR:      cfg_q.stop_pair      <= cfg_wdata_i[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/irpte_seq.sv =====
// Segment sequencer: walks start, data and stop phases, one segment per step.
`default_nettype none

module irpte_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irpte_pkg::cfg_t              cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [irpte_pkg::DATA_W-1:0] data_value_i,
  output logic                         seg_valid_o,
  input  logic                         seg_ready_i,
  output irpte_pkg::seg_t              seg_o
);
  import irpte_pkg::*;

  seq_state_e        state_q, state_d;
  logic              half_q, half_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] value_q, value_d;

  logic              accept;
  logic              adv;
  logic              last_bit;
  logic [CNT_W-1:0]  nbits;
  logic [PAIR_W-1:0] pair;
  logic [SEG_W-1:0]  seg_raw;
  logic              seg_last;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign adv      = (state_q != ST_IDLE) && seg_ready_i;
  assign last_bit = (left_q == CNT_W'(1));
  assign nbits    = (cfg_i.bit_count > BC_W'(MAX_DATA_BITS)) ? CNT_W'(MAX_DATA_BITS)
                                                             : CNT_W'(cfg_i.bit_count);

  always_comb begin
    state_d = state_q;
    half_d  = half_q;
    left_d  = left_q;
    pos_d   = pos_q;
    value_d = value_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = data_value_i;
          left_d  = nbits;
          pos_d   = cfg_i.msb_first ? POS_W'(nbits - CNT_W'(1)) : '0;
          half_d  = 1'b0;
          if (cfg_i.framing_enable[0]) begin
            state_d = ST_START;
          end else if (nbits != '0) begin
            state_d = ST_DATA;
          end else if (cfg_i.framing_enable[1]) begin
            state_d = ST_STOP;
          end
        end
      end
      ST_START: begin
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            if (left_q != '0) begin
              state_d = ST_DATA;
            end else begin
              state_d = cfg_i.framing_enable[1] ? ST_STOP : ST_IDLE;
            end
          end
        end
      end
      ST_DATA: begin
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            left_d = left_q - CNT_W'(1);
            pos_d  = cfg_i.msb_first ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
            if (last_bit) begin
              state_d = cfg_i.framing_enable[1] ? ST_STOP : ST_IDLE;
            end
          end
        end
      end
      ST_STOP: begin
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pair     = cfg_i.start_pair;
    seg_last = 1'b0;
    case (state_q)
      ST_START: begin
        pair     = cfg_i.start_pair;
        seg_last = half_q && (left_q == '0) && !cfg_i.framing_enable[1];
      end
      ST_DATA: begin
        pair     = value_q[pos_q] ? cfg_i.one_pair : cfg_i.zero_pair;
        seg_last = half_q && last_bit && !cfg_i.framing_enable[1];
      end
      ST_STOP: begin
        pair     = cfg_i.stop_pair;
        seg_last = half_q;
      end
      default: begin
        pair     = cfg_i.start_pair;
        seg_last = 1'b0;
      end
    endcase
    seg_raw     = half_q ? pair[PAIR_W-1:SEG_W] : pair[SEG_W-1:0];
    seg_o.level = seg_raw[LEVEL_POS] ^ cfg_i.neg_logic;
    seg_o.ticks = TICKS_W'(seg_raw[TICK_BITS-1:0]);
    seg_o.last  = seg_last;
  end

  assign seg_valid_o = (state_q != ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      half_q  <= 1'b0;
      left_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/irpte_out.sv =====
// Output register stage for emitted segments.
`default_nettype none

module irpte_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          seg_valid_i,
  output logic                          seg_ready_o,
  input  irpte_pkg::seg_t               seg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pulse_level_o,
  output logic [irpte_pkg::TICKS_W-1:0] pulse_ticks_o,
  output logic                          last_pulse_o
);
  import irpte_pkg::*;

  logic valid_q, valid_d;
  seg_t seg_q;
  logic load;

  assign seg_ready_o = !valid_q || out_ready_i;
  assign load        = seg_valid_i && seg_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_q <= seg_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign pulse_level_o = seg_q.level;
  assign pulse_ticks_o = seg_q.ticks;
  assign last_pulse_o  = seg_q.last;

endmodule

`default_nettype wire

// ===== rtl/core/irpte_checker.sv =====
// Port-level assertions for the infrared pulse train encoder, with its bind.
`default_nettype none

module irpte_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [irpte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [irpte_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [irpte_pkg::DATA_W-1:0]     data_value_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             pulse_level_o,
  input logic [irpte_pkg::TICKS_W-1:0]    pulse_ticks_o,
  input logic                             last_pulse_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pulse_level_o) && $stable(pulse_ticks_o) &&
      $stable(last_pulse_o))
    else $error("output beat changed while stalled");

  a_busy_mid_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pulse_o |-> !in_ready_o)
    else $error("input ready while a pulse train is still in progress");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output beat present straight after reset");

endmodule

bind ir_pulse_train_encoder irpte_checker u_irpte_checker (.*);

`default_nettype wire

// ===== verif/irpte_train_checker.sv =====
// Checker for the pulse train encoder: tracks the registers, predicts the segments, compares beats.
module irpte_train_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpte_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [irpte_pkg::DATA_W-1:0]     data_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic                             pulse_level_i,
  input  logic [irpte_pkg::TICKS_W-1:0]    pulse_ticks_i,
  input  logic                             last_pulse_i,
  output int                               err_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import irpte_pkg::*;

  localparam int PRINT_CAP = 40;

  logic              neg_q;
  logic              msb_q;
  logic [BC_W-1:0]   nbits_q;
  logic [FE_W-1:0]   frame_q;
  logic [PAIR_W-1:0] start_q;
  logic [PAIR_W-1:0] zero_q;
  logic [PAIR_W-1:0] one_q;
  logic [PAIR_W-1:0] stop_q;

  seg_t train_q[$];
  int   errors;

  task automatic report(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic seg_t make_seg(input logic [SEG_W-1:0] raw);
    seg_t s;
    s.level = raw[LEVEL_POS] ^ neg_q;
    s.ticks = raw[TICKS_W-1:0];
    s.last  = 1'b0;
    return s;
  endfunction

  task automatic queue_pair(input logic [PAIR_W-1:0] pair);
    train_q.push_back(make_seg(pair[SEG_W-1:0]));
    train_q.push_back(make_seg(pair[PAIR_W-1:SEG_W]));
  endtask

  task automatic predict_train(input logic [DATA_W-1:0] value);
    int   nbits;
    int   pos;
    int   first;
    seg_t tail;
    first = train_q.size();
    nbits = (int'(nbits_q) > MAX_DATA_BITS) ? MAX_DATA_BITS : int'(nbits_q);
    if (frame_q[0]) queue_pair(start_q);
    for (int i = 0; i < nbits; i++) begin
      pos = msb_q ? (nbits - 1 - i) : i;
      queue_pair(value[pos] ? one_q : zero_q);
    end
    if (frame_q[1]) queue_pair(stop_q);
    if (train_q.size() > first) begin
      tail = train_q.pop_back();
      tail.last = 1'b1;
      train_q.push_back(tail);
    end
  endtask

  task automatic check_segment();
    seg_t want;
    if (train_q.size() == 0) begin
      report($sformatf("segment with nothing predicted: level %0d ticks %0h last %0d",
                       pulse_level_i, pulse_ticks_i, last_pulse_i));
    end else begin
      want = train_q.pop_front();
      if (pulse_level_i !== want.level)
        report($sformatf("pulse_level expected %0d got %0d", want.level, pulse_level_i));
      if (pulse_ticks_i !== want.ticks)
        report($sformatf("pulse_ticks expected %0h got %0h", want.ticks, pulse_ticks_i));
      if (last_pulse_i !== want.last)
        report($sformatf("last_pulse expected %0d got %0d", want.last, last_pulse_i));
    end
  endtask

  initial begin
    errors = 0;
    err_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q   = 1'b0;
      msb_q   = 1'b0;
      nbits_q = BIT_COUNT_RST;
      frame_q = '0;
      start_q = '0;
      zero_q  = '0;
      one_q   = '0;
      stop_q  = '0;
      train_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_NEG_LOGIC:      neg_q   = cfg_wdata_i[0];
          REG_MSB_FIRST:      msb_q   = cfg_wdata_i[0];
          REG_BIT_COUNT:      nbits_q = cfg_wdata_i[BC_W-1:0];
          REG_FRAMING_ENABLE: frame_q = cfg_wdata_i[FE_W-1:0];
          REG_START_PAIR:     start_q = cfg_wdata_i[PAIR_W-1:0];
          REG_ZERO_PAIR:      zero_q  = cfg_wdata_i[PAIR_W-1:0];
          REG_ONE_PAIR:       one_q   = cfg_wdata_i[PAIR_W-1:0];
          REG_STOP_PAIR:      stop_q  = cfg_wdata_i[PAIR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_train(data_value_i);
      if (out_valid_i && out_ready_i) check_segment();
    end
    pending_o   = train_q.size();
    err_count_o = errors;
  end

endmodule

// ===== verif/tb_ir_pulse_train_encoder.sv =====
// Testbench top for the pulse train encoder: clock, reset, register settings, beats and verdict.
module tb_ir_pulse_train_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import irpte_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 100;
  localparam int LONG_HOLD     = 400;
  localparam logic [DATA_W-1:0] DATA_ONES = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [DATA_W-1:0]     data_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  pulse_level;
  logic [TICKS_W-1:0]    pulse_ticks;
  logic                  last_pulse;

  int err_count;
  int pending;
  int idle_cycles;
  int rx_hold_req;
  bit quiet_mode;

  ir_pulse_train_encoder uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_value_i (data_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pulse_level_o(pulse_level),
    .pulse_ticks_o(pulse_ticks),
    .last_pulse_o (last_pulse)
  );

  irpte_train_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_value_i (data_value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .pulse_level_i(pulse_level),
    .pulse_ticks_i(pulse_ticks),
    .last_pulse_i (last_pulse),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return quiet_mode ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CFG_DATA_W-1:0];
  endfunction

  // fill the bits above the register width with noise
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << w) - 1'b1;
    return (rand_word() & ~keep) | (v & keep);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DATA_ONES;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic cfg_t make_cfg(input logic neg, input logic msb, input int nbits,
                                    input int frame, input logic [PAIR_W-1:0] sp,
                                    input logic [PAIR_W-1:0] zp, input logic [PAIR_W-1:0] op,
                                    input logic [PAIR_W-1:0] tp);
    cfg_t c;
    c.neg_logic      = neg;
    c.msb_first      = msb;
    c.bit_count      = BC_W'(nbits);
    c.framing_enable = FE_W'(frame);
    c.start_pair     = sp;
    c.zero_pair      = zp;
    c.one_pair       = op;
    c.stop_pair      = tp;
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_NEG_LOGIC, with_junk(CFG_DATA_W'(c.neg_logic), 1));
    write_reg(REG_MSB_FIRST, with_junk(CFG_DATA_W'(c.msb_first), 1));
    write_reg(REG_BIT_COUNT, with_junk(CFG_DATA_W'(c.bit_count), BC_W));
    write_reg(REG_FRAMING_ENABLE, with_junk(CFG_DATA_W'(c.framing_enable), FE_W));
    write_reg(REG_START_PAIR, c.start_pair);
    write_reg(REG_ZERO_PAIR, c.zero_pair);
    write_reg(REG_ONE_PAIR, c.one_pair);
    write_reg(REG_STOP_PAIR, c.stop_pair);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_value(input logic [DATA_W-1:0] v);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every predicted beat, then let the sequencer drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    int burst;
    cfg_t c;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    data_value  = '0;
    idle_cycles = 0;
    rx_hold_req = 0;
    quiet_mode  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of the registers
    send_value('0);
    send_value(DATA_ONES);
    settle();

    // full frame at the widest count, with a long receiver hold-off
    apply_cfg(make_cfg(1'b0, 1'b0, MAX_DATA_BITS, 3,
                       {1'b0, 16'd4500, 1'b1, 16'd9000}, {1'b0, 16'd560, 1'b1, 16'd560},
                       {1'b0, 16'd1690, 1'b1, 16'd560}, {1'b0, 16'hFFFF, 1'b1, 16'h0000}));
    rx_hold_req = LONG_HOLD;
    send_value('0);
    send_value(DATA_ONES);
    send_value(30'h2AAAAAAA);
    send_value(30'h15555555);
    settle();

    // inverted levels, msb first, bit count above the limit
    apply_cfg(make_cfg(1'b1, 1'b1, 31, 1, '1, '0, '1, {1'b1, 16'hFFFF, 1'b0, 16'h0000}));
    send_value(DATA_ONES);
    send_value(30'h12345678);
    send_value(30'd1);
    settle();

    // empty frame
    apply_cfg(make_cfg(1'b0, 1'b0, 0, 0, rand_word(), rand_word(), rand_word(), rand_word()));
    send_value(DATA_ONES);
    send_value('0);
    send_value(rand_value());
    settle();

    // stop pair only
    apply_cfg(make_cfg(1'b1, 1'b0, 0, 2, rand_word(), rand_word(), rand_word(), rand_word()));
    send_value('0);
    send_value(DATA_ONES);
    settle();

    // single data bit
    apply_cfg(make_cfg(1'b0, 1'b1, 1, 0, rand_word(), rand_word(), rand_word(), rand_word()));
    send_value('0);
    send_value(30'd1);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c = make_cfg(1'($urandom()), 1'($urandom()), $urandom_range(0, 31),
                   $urandom_range(0, 3), rand_word(), rand_word(), rand_word(), rand_word());
      apply_cfg(c);
      quiet_mode = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 16);
      repeat (burst) send_value(rand_value());
      sent += burst;
      settle();
      quiet_mode = 1'b0;
    end

    settle();
    repeat (16) @(negedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
